// ===== rtl/deadline_timer_table_unit_defines.svh =====
// Assertion macros shared by the deadline timer table RTL.
`ifndef DEADLINE_TIMER_TABLE_UNIT_DEFINES_SVH
`define DEADLINE_TIMER_TABLE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define DTT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("deadline timer table assertion failed");
`define DTT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("deadline timer table illegal condition");
`else
`define DTT_ASSERT(lbl, prop)
`define DTT_NEVER(lbl, expr)
`endif

`endif

// ===== rtl/dtt_pkg.sv =====
// Shared constants, types and state encoding for the deadline timer table.
`timescale 1ns / 1ps

package dtt_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int ID_CMP_W   = 8;

    localparam int TID_W     = 4;
    localparam int TMO_W     = 32;
    localparam int TAG_W     = 16;
    localparam int TIME_W    = 48;
    localparam int DELAY_W   = 31;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 56;
    localparam int S_PAD_W   = S_TDATA_W - (TID_W + TMO_W + TAG_W + 1 + TIME_W);
    localparam int M_PAD_W   = M_TDATA_W - (TID_W + TAG_W + 1 + DELAY_W);

    localparam logic       OP_SET     = 1'b0;
    localparam logic       OP_CHECK   = 1'b1;
    localparam logic       KIND_FIRE  = 1'b0;
    localparam logic       KIND_DONE  = 1'b1;
    localparam logic [TMO_W-1:0] TMO_RESUME = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,   // last table read is still being compared
        ST_DECIDE
    } dtt_state_t;

    typedef struct packed {
        logic set_en;       // apply a set request this cycle
        logic check_start;  // capture now and start the first scan
        logic scan_step;    // examine one table entry
        logic load_fire;    // load an expiry report, disarm, rescan
        logic load_final;   // load the closing delay result
    } dtt_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
        logic expired;
    } dtt_sts_t;

endpackage

// ===== rtl/deadline_timer_table_unit.sv =====
// Top level of the deadline timer table: stream ports, controller and datapath.
`timescale 1ns / 1ps

// Deadline timer table for dtt_pkg::NUM_TIMERS timers. A set request
// (s_tuser = 0) is applied when accepted and produces no result. A check request
// (s_tuser = 1) finds the earliest armed deadline by walking the table one entry
// per cycle through a registered table read and a single 48-bit compare; each
// walk reads every entry, finishes the last compare in a flush step and then
// loads one result, either an expiry report (after which the timer is disarmed
// and the walk repeats) or the closing delay result with tlast set. Each load
// waits while the output register is still held by the downstream side. No new
// request is taken until the closing result has been loaded into the output
// register.
module deadline_timer_table_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // timer_id[3:0], timeout_ms[35:4], tag[51:36], notify[52], now_ms[100:53], zeros
    input  logic [dtt_pkg::S_TDATA_W-1:0]   s_tdata,
    // op[0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // fired_id[3:0], fired_tag[19:4], fired_notify[20], delay_ms[51:21], zeros
    output logic [dtt_pkg::M_TDATA_W-1:0]   m_tdata,
    // kind[0]
    output logic                            m_tuser,
    output logic                            m_tlast
);

    dtt_pkg::dtt_cmd_t cmd;
    dtt_pkg::dtt_sts_t sts;

    logic [dtt_pkg::TID_W-1:0]   in_timer_id;
    logic [dtt_pkg::TMO_W-1:0]   in_timeout;
    logic [dtt_pkg::TAG_W-1:0]   in_tag;
    logic                        in_notify;
    logic [dtt_pkg::TIME_W-1:0]  in_now;

    logic [dtt_pkg::TID_W-1:0]   out_id;
    logic [dtt_pkg::TAG_W-1:0]   out_tag;
    logic                        out_notify;
    logic [dtt_pkg::DELAY_W-1:0] out_delay;

    assign {in_now, in_notify, in_tag, in_timeout, in_timer_id} =
        s_tdata[dtt_pkg::S_TDATA_W-dtt_pkg::S_PAD_W-1:0];

    dtt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (s_tready)
    );

    dtt_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_timer_id (in_timer_id),
        .in_timeout  (in_timeout),
        .in_tag      (in_tag),
        .in_notify   (in_notify),
        .in_now      (in_now),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (m_tuser),
        .out_id      (out_id),
        .out_tag     (out_tag),
        .out_notify  (out_notify),
        .out_delay   (out_delay),
        .out_last    (m_tlast)
    );

    assign m_tdata = {{dtt_pkg::M_PAD_W{1'b0}}, out_delay, out_notify, out_tag, out_id};

endmodule

// ===== rtl/dtt_datapath.sv =====
// Timer table storage, earliest-deadline scan and output register.
`timescale 1ns / 1ps
`include "deadline_timer_table_unit_defines.svh"

module dtt_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [dtt_pkg::TID_W-1:0]     in_timer_id,
    input  logic [dtt_pkg::TMO_W-1:0]     in_timeout,
    input  logic [dtt_pkg::TAG_W-1:0]     in_tag,
    input  logic                          in_notify,
    input  logic [dtt_pkg::TIME_W-1:0]    in_now,
    input  dtt_pkg::dtt_cmd_t             cmd,
    output dtt_pkg::dtt_sts_t             sts,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_kind,
    output logic [dtt_pkg::TID_W-1:0]     out_id,
    output logic [dtt_pkg::TAG_W-1:0]     out_tag,
    output logic                          out_notify,
    output logic [dtt_pkg::DELAY_W-1:0]   out_delay,
    output logic                          out_last
);

    logic [dtt_pkg::TIME_W-1:0] deadline_mem [dtt_pkg::NUM_TIMERS];
    logic [dtt_pkg::TAG_W-1:0]  tag_mem      [dtt_pkg::NUM_TIMERS];
    logic                       notify_mem   [dtt_pkg::NUM_TIMERS];

    logic [dtt_pkg::NUM_TIMERS-1:0] armed_reg, armed_next;
    logic [dtt_pkg::NUM_TIMERS-1:0] enabled_reg, enabled_next;

    logic [dtt_pkg::IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic [dtt_pkg::IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [dtt_pkg::TIME_W-1:0] best_d_reg, best_d_next;
    logic                       best_valid_reg, best_valid_next;
    logic [dtt_pkg::TIME_W-1:0] now_reg;

    logic [dtt_pkg::TIME_W-1:0] scan_d_reg;
    logic [dtt_pkg::IDX_W-1:0]  cmp_idx_reg;
    logic                       cmp_valid_reg;

    logic                       out_valid_reg, out_valid_next;
    logic                       out_kind_reg;
    logic [dtt_pkg::TID_W-1:0]  out_id_reg;
    logic [dtt_pkg::TAG_W-1:0]  out_tag_reg;
    logic                       out_notify_reg;
    logic [dtt_pkg::DELAY_W-1:0] out_delay_reg;
    logic                       out_last_reg;

    logic [dtt_pkg::IDX_W-1:0]  set_idx;
    logic                       id_ok;
    logic                       is_pos, is_zero, is_resume;
    logic                       set_write;
    logic [dtt_pkg::TIME_W:0]   sum_full;
    logic [dtt_pkg::TIME_W-1:0] set_deadline;
    logic                       entry_hit;
    logic [dtt_pkg::TIME_W-1:0] diff;
    logic [dtt_pkg::DELAY_W-1:0] delay_sat;
    logic                       scan_start;

    // set request decode
    assign set_idx   = dtt_pkg::IDX_W'(in_timer_id);
    assign id_ok     = dtt_pkg::ID_CMP_W'(in_timer_id) < dtt_pkg::ID_CMP_W'(dtt_pkg::NUM_TIMERS);
    assign is_zero   = (in_timeout == '0);
    assign is_pos    = !is_zero && !in_timeout[dtt_pkg::TMO_W-1];
    assign is_resume = (in_timeout == dtt_pkg::TMO_RESUME);
    assign set_write = cmd.set_en && id_ok && is_pos;

    assign sum_full     = {1'b0, in_now} + (dtt_pkg::TIME_W + 1)'(in_timeout);
    assign set_deadline = sum_full[dtt_pkg::TIME_W] ? '1 : sum_full[dtt_pkg::TIME_W-1:0];

    always_comb
    begin
        armed_next   = armed_reg;
        enabled_next = enabled_reg;
        if (cmd.set_en && id_ok)
        begin
            if (is_pos)
            begin
                armed_next[set_idx]   = 1'b1;
                enabled_next[set_idx] = 1'b1;
            end
            else if (is_zero)
            begin
                armed_next[set_idx]   = 1'b0;
                enabled_next[set_idx] = 1'b0;
            end
            else if (is_resume)
            begin
                if (enabled_reg[set_idx])
                    armed_next[set_idx] = 1'b1;
            end
            else
            begin
                armed_next[set_idx] = 1'b0;
            end
        end
        if (cmd.load_fire)
            armed_next[best_idx_reg] = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (set_write)
        begin
            deadline_mem[set_idx] <= set_deadline;
            tag_mem[set_idx]      <= in_tag;
            notify_mem[set_idx]   <= in_notify;
        end
    end

    // registered table read; the compare runs in the cycle after the read address is applied
    always_ff @(posedge clk)
    begin
        scan_d_reg  <= deadline_mem[scan_idx_reg];
        cmp_idx_reg <= scan_idx_reg;
    end

    // one entry per cycle against the running minimum
    assign scan_start = cmd.check_start || cmd.load_fire;
    assign entry_hit  = cmp_valid_reg && armed_reg[cmp_idx_reg]
                        && (!best_valid_reg || (scan_d_reg < best_d_reg));

    always_comb
    begin
        scan_idx_next   = scan_idx_reg;
        best_idx_next   = best_idx_reg;
        best_d_next     = best_d_reg;
        best_valid_next = best_valid_reg;
        if (scan_start)
        begin
            scan_idx_next   = '0;
            best_valid_next = 1'b0;
        end
        else
        begin
            if (cmd.scan_step)
                scan_idx_next = dtt_pkg::IDX_W'(scan_idx_reg + 1'b1);
            if (entry_hit)
            begin
                best_idx_next   = cmp_idx_reg;
                best_d_next     = scan_d_reg;
                best_valid_next = 1'b1;
            end
        end
    end

    assign diff      = best_d_reg - now_reg;
    assign delay_sat = (|diff[dtt_pkg::TIME_W-1:dtt_pkg::DELAY_W]) ? '1
                                                                  : diff[dtt_pkg::DELAY_W-1:0];

    assign sts.scan_last = (scan_idx_reg == dtt_pkg::IDX_W'(dtt_pkg::NUM_TIMERS - 1));
    assign sts.out_free  = !out_valid_reg || out_ready;
    assign sts.expired   = best_valid_reg && (best_d_reg <= now_reg);

    assign out_valid_next = (cmd.load_fire || cmd.load_final) ? 1'b1
                          : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg      <= '0;
            enabled_reg    <= '0;
            scan_idx_reg   <= '0;
            best_valid_reg <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            armed_reg      <= armed_next;
            enabled_reg    <= enabled_next;
            scan_idx_reg   <= scan_idx_next;
            best_valid_reg <= best_valid_next;
            cmp_valid_reg  <= cmd.scan_step;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg <= best_idx_next;
        best_d_reg   <= best_d_next;
        if (cmd.check_start)
            now_reg <= in_now;
        if (cmd.load_fire)
        begin
            out_kind_reg   <= dtt_pkg::KIND_FIRE;
            out_id_reg     <= dtt_pkg::TID_W'(best_idx_reg);
            out_tag_reg    <= tag_mem[best_idx_reg];
            out_notify_reg <= notify_mem[best_idx_reg];
            out_delay_reg  <= '0;
            out_last_reg   <= 1'b0;
        end
        else if (cmd.load_final)
        begin
            out_kind_reg   <= dtt_pkg::KIND_DONE;
            out_id_reg     <= '0;
            out_tag_reg    <= '0;
            out_notify_reg <= 1'b0;
            out_delay_reg  <= best_valid_reg ? delay_sat : '0;
            out_last_reg   <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_id     = out_id_reg;
    assign out_tag    = out_tag_reg;
    assign out_notify = out_notify_reg;
    assign out_delay  = out_delay_reg;
    assign out_last   = out_last_reg;

    `DTT_ASSERT(a_load_when_free, (cmd.load_fire || cmd.load_final) |-> sts.out_free)
    `DTT_ASSERT(a_fire_is_due, cmd.load_fire |-> (best_valid_reg && best_d_reg <= now_reg))
    `DTT_ASSERT(a_fire_disarms, cmd.load_fire |=> !armed_reg[$past(best_idx_reg)])

endmodule

// ===== rtl/dtt_ctrl.sv =====
// Sequencer for set requests, table scans and result loading.
`timescale 1ns / 1ps
`include "deadline_timer_table_unit_defines.svh"

module dtt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_op,
    input  dtt_pkg::dtt_sts_t   sts,
    output dtt_pkg::dtt_cmd_t   cmd,
    output logic                in_ready
);

    dtt_pkg::dtt_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= dtt_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dtt_pkg::ST_IDLE:
            begin
                if (in_valid && in_op == dtt_pkg::OP_CHECK)
                    state_next = dtt_pkg::ST_SCAN;
            end
            dtt_pkg::ST_SCAN:
            begin
                if (sts.scan_last)
                    state_next = dtt_pkg::ST_FLUSH;
            end
            dtt_pkg::ST_FLUSH:
            begin
                state_next = dtt_pkg::ST_DECIDE;
            end
            dtt_pkg::ST_DECIDE:
            begin
                if (sts.out_free)
                    state_next = sts.expired ? dtt_pkg::ST_SCAN : dtt_pkg::ST_IDLE;
            end
            default: state_next = dtt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            dtt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_op == dtt_pkg::OP_SET)
                        cmd.set_en = 1'b1;
                    else
                        cmd.check_start = 1'b1;
                end
            end
            dtt_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            dtt_pkg::ST_FLUSH:
            begin
                cmd = '0;
            end
            dtt_pkg::ST_DECIDE:
            begin
                if (sts.out_free)
                begin
                    if (sts.expired)
                        cmd.load_fire = 1'b1;
                    else
                        cmd.load_final = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end

    `DTT_ASSERT(a_cmd_onehot, $onehot0({cmd.set_en, cmd.check_start, cmd.scan_step,
                                        cmd.load_fire, cmd.load_final}))

endmodule
